FILE: hdl/vaos_pkg.sv
// Shared types and codes for the voice allocator.
`timescale 1ns / 1ps
package vaos_pkg;

  // Input opcodes carried on the slave tuser line.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Per-cycle control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;  // start a new search
    logic valid;  // one voice is presented this cycle
  } scan_ctrl_t;

endpackage

FILE: hdl/vaos_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module vaos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/vaos_scan.sv
// Shared compare unit: finds the first idle voice and the oldest start time, one voice a cycle.
`timescale 1ns / 1ps
module vaos_scan #(
  parameter int IDX_W = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vaos_pkg::scan_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic                busy_i,
  input  logic [31:0]         time_i,
  output logic                found_o,
  output logic [IDX_W-1:0]    idle_idx_o,
  output logic [IDX_W-1:0]    min_idx_o
);
  import vaos_pkg::*;

  logic             found_q, found_d;
  logic             have_min_q, have_min_d;
  logic [IDX_W-1:0] idle_idx_q, idle_idx_d;
  logic [IDX_W-1:0] min_idx_q, min_idx_d;
  logic [31:0]      min_time_q, min_time_d;

  always_comb begin
    found_d    = found_q;
    have_min_d = have_min_q;
    idle_idx_d = idle_idx_q;
    min_idx_d  = min_idx_q;
    min_time_d = min_time_q;
    if (ctrl_i.clear) begin
      found_d    = 1'b0;
      have_min_d = 1'b0;
    end else if (ctrl_i.valid) begin
      if (!busy_i && !found_q) begin
        found_d    = 1'b1;
        idle_idx_d = idx_i;
      end
      // strict less-than keeps the lowest index on ties
      if (!have_min_q || (time_i < min_time_q)) begin
        have_min_d = 1'b1;
        min_idx_d  = idx_i;
        min_time_d = time_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      have_min_q <= 1'b0;
    end else begin
      found_q    <= found_d;
      have_min_q <= have_min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idle_idx_q <= idle_idx_d;
    min_idx_q  <= min_idx_d;
    min_time_q <= min_time_d;
  end

  assign found_o    = found_q;
  assign idle_idx_o = idle_idx_q;
  assign min_idx_o  = min_idx_q;

endmodule

FILE: hdl/voice_allocator_oldest_steal.sv
// Voice allocator top level: sequencer, busy flags, start-time RAM, scan unit and result register.
//
//  Channel   Direction  tdata (low bit up)                                 tuser
//  s_axis    in         voice_index[3:0], now_time[35:4], pad               opcode
//  m_axis    out        granted[0], granted_voice[4:1], stolen[5],          -
//                       busy_count[10:6], pad
//  cfg       in         steal_enable on cfg_wdata_i, written when cfg_we_i  -
//
// Allocate passes through the scan state and the final state to the result: the scan
// reads one start time per cycle from the single RAM read port through one 32-bit
// comparator. Release goes straight to the final state. Ready is high only while the
// sequencer is idle, so a new request waits until the last result has been loaded.
// A stalled result holds the sequencer in its final state; state updates land
// when the result is loaded. Reset (async, active low) idles every voice and
// sets steal_enable; start times need no clearing.
`timescale 1ns / 1ps
module voice_allocator_oldest_steal #(
  parameter int NUM_VOICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // voice_index[3:0], now_time[35:4]
  input  logic        s_axis_tuser_i,   // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // granted, granted_voice[4:1], stolen, busy_count[10:6]
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import vaos_pkg::*;

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNTW = VW + 1;
  localparam int CW = $clog2(NUM_VOICES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic                  steal_en_q;
  logic                  op_q, op_d;
  logic [3:0]            vidx_q, vidx_d;
  logic [31:0]           now_q, now_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic                  cmp_valid_q, cmp_valid_d;
  logic [VW-1:0]         cmp_idx_q, cmp_idx_d;
  logic [NUM_VOICES-1:0] busy_q, busy_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic [15:0]           out_data_q, out_data_d;

  scan_ctrl_t    scan_ctrl;
  logic          found;
  logic [VW-1:0] idle_idx, min_idx;
  logic [31:0]   ram_rdata;
  logic          ram_re, ram_we;
  logic [VW-1:0] ram_waddr;

  logic          in_fire, out_free, cnt_live, rel_in_range;
  logic          granted, stolen;
  logic [VW-1:0] pick, rel_idx;
  logic [3:0]    gvoice;

  assign in_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free     = !out_valid_q || m_axis_tready_i;
  assign cnt_live     = cnt_q < CNTW'(NUM_VOICES);
  assign rel_in_range = 32'(vidx_q) < 32'(NUM_VOICES);
  assign rel_idx      = VW'(vidx_q);
  assign ram_re       = (state_q == ST_SCAN) && cnt_live;

  vaos_ram #(
    .WIDTH(32),
    .DEPTH(NUM_VOICES)
  ) u_start_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(now_q),
    .re_i   (ram_re),
    .raddr_i(cnt_q[VW-1:0]),
    .rdata_o(ram_rdata)
  );

  vaos_scan #(
    .IDX_W(VW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .idx_i     (cmp_idx_q),
    .busy_i    (busy_q[cmp_idx_q]),
    .time_i    (ram_rdata),
    .found_o   (found),
    .idle_idx_o(idle_idx),
    .min_idx_o (min_idx)
  );

  assign scan_ctrl.clear = in_fire;
  assign scan_ctrl.valid = cmp_valid_q;

  // allocate decision, used in the final state
  always_comb begin
    granted = 1'b0;
    stolen  = 1'b0;
    pick    = idle_idx;
    if (found) begin
      granted = 1'b1;
    end else if (steal_en_q) begin
      granted = 1'b1;
      stolen  = 1'b1;
      pick    = min_idx;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    vidx_d      = vidx_q;
    now_d       = now_q;
    cnt_d       = cnt_q;
    cmp_valid_d = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    busy_d      = busy_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = pick;
    gvoice      = 4'd0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d   = s_axis_tuser_i;
          vidx_d = s_axis_tdata_i[3:0];
          now_d  = s_axis_tdata_i[35:4];
          cnt_d  = '0;
          state_d = (s_axis_tuser_i == OP_ALLOC) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (cnt_live) begin
          cmp_valid_d = 1'b1;
          cmp_idx_d   = cnt_q[VW-1:0];
          cnt_d       = cnt_q + CNTW'(1);
        end else if (!cmp_valid_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          if (op_q == OP_RELEASE) begin
            gvoice = vidx_q;
            if (rel_in_range && busy_q[rel_idx]) begin
              busy_d[rel_idx] = 1'b0;
              count_d = count_q - CW'(1);
            end
          end else if (granted) begin
            gvoice       = 4'(pick);
            ram_we       = 1'b1;
            busy_d[pick] = 1'b1;
            if (!stolen) begin
              count_d = count_q + CW'(1);
            end
          end
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, 5'(count_d), stolen && (op_q == OP_ALLOC), gvoice,
                         granted && (op_q == OP_ALLOC)};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      steal_en_q  <= 1'b1;
      cmp_valid_q <= 1'b0;
      busy_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= cmp_valid_d;
      busy_q      <= busy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        steal_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    vidx_q     <= vidx_d;
    now_q      <= now_d;
    cmp_idx_q  <= cmp_idx_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
